// ----- hdl/ssba_pkg.sv -----
package ssba_pkg;

   localparam int MAX_SLOTS        = 1024;
   localparam int SECTORS_PER_SLOT = 8;
   localparam int SECTOR_BYTES     = 512;
   localparam int PAGE_BYTES       = 4096;

   localparam int ROW_BITS     = 32;
   localparam int ROWS         = MAX_SLOTS / ROW_BITS;
   localparam int ROW_W        = $clog2(ROWS);
   localparam int BIT_W        = $clog2(ROW_BITS);
   localparam int SLOT_W       = 10;
   localparam int COUNT_W      = 11;
   localparam int FRAME_W      = 20;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int SECTOR_W     = 13;
   localparam int MEM_ADDR_W   = 32;
   localparam int STEP_W       = $clog2(SECTORS_PER_SLOT);
   localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int LIM_W        = COUNT_W - BIT_W;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 3;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(MAX_SLOTS);
   localparam logic [CSR_ADDR_W-3:0] REG_SLOT_COUNT = '0;

   localparam logic [CMD_W-1:0] CMD_OUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_IN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

   typedef struct packed {
      logic load;
      logic read;
      logic check;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic none;
      logic out_free;
      logic emit_last;
   } dp_stat_type;

   // lowest set bit wins
   function automatic logic [BIT_W-1:0] first_bit(input logic [ROW_BITS-1:0] v);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
      logic [ROW_W-1:0] pos;
      pos = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = ROW_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- hdl/swap_slot_bitmap_allocator_top.sv -----
// First-fit swap slot allocator over a 1024-slot free map (all free after reset).
// Commands arrive one at a time; an accepted transaction looks up the map (one row
// read of the 32x32 map memory plus decision), then emits 8 sector transfers for
// swap out/in or a single status result, one per cycle while the result side is
// ready; a no-op emits nothing. A new command is taken as soon as its predecessor's
// last result sits in the output register. Lowest free slot is located through a
// per-row summary bitmap, so search time does not depend on map occupancy.
module swap_slot_bitmap_allocator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ssba_pkg::REQ_DATA_W-1:0]      req_tdata,  // slot_index, frame_number, pad
   input  logic [ssba_pkg::CMD_W-1:0]           req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ssba_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // slot, device_sector, memory_address, pad
   output logic [ssba_pkg::RSP_USER_W-1:0]      rsp_tuser,  // status, transfer
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ssba_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ssba_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ssba_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   ssba_pkg::ctl_cmd_type          ctl_cmd;
   ssba_pkg::dp_stat_type          dp_stat;
   logic [ssba_pkg::COUNT_W-1:0]   eff_count;

   ssba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_count   (eff_count)
   );

   ssba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ctl_cmd    (ctl_cmd),
      .dp_stat    (dp_stat)
   );

   ssba_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl_cmd    (ctl_cmd),
      .dp_stat    (dp_stat),
      .eff_count  (eff_count),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hdl/ssba_csr.sv -----
module ssba_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ssba_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ssba_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ssba_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic [ssba_pkg::COUNT_W-1:0]         eff_count
);

   logic [ssba_pkg::COUNT_W-1:0] slot_count_ff;
   logic [ssba_pkg::COUNT_W-1:0] slot_count_in;
   logic                         hit;

   assign csr_pready = 1'b1;
   assign hit = (csr_paddr[ssba_pkg::CSR_ADDR_W-1:2] == ssba_pkg::REG_SLOT_COUNT);

   always_comb begin
      slot_count_in = slot_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         slot_count_in = csr_pwdata[ssba_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= ssba_pkg::SLOT_COUNT_RESET;
      end else begin
         slot_count_ff <= slot_count_in;
      end
   end

   assign csr_prdata = hit ? ssba_pkg::CSR_DATA_W'(slot_count_ff) : '0;

   // saturate at the map size
   assign eff_count = (slot_count_ff < ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS)) ?
                      slot_count_ff : ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS);

endmodule

// ----- hdl/ssba_dp.sv -----
module ssba_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssba_pkg::ctl_cmd_type                ctl_cmd,
   output ssba_pkg::dp_stat_type                dp_stat,
   input  logic [ssba_pkg::COUNT_W-1:0]         eff_count,
   input  logic [ssba_pkg::CMD_W-1:0]           req_tuser,
   input  logic [ssba_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ssba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [ssba_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   // transaction latch
   logic [ssba_pkg::CMD_W-1:0]      cmd_ff;
   logic [ssba_pkg::SLOT_W-1:0]     idx_ff;
   logic [ssba_pkg::FRAME_W-1:0]    frame_ff;

   // free map: one bit per slot, rows of ROW_BITS slots
   logic [ssba_pkg::ROW_BITS-1:0]   map_mem [ssba_pkg::ROWS];
   logic [ssba_pkg::ROW_BITS-1:0]   q_ff;
   logic [ssba_pkg::ROWS-1:0]       row_valid_ff;
   logic [ssba_pkg::ROWS-1:0]       row_valid_in;
   logic [ssba_pkg::ROWS-1:0]       summary_ff;
   logic [ssba_pkg::ROWS-1:0]       summary_in;
   logic [ssba_pkg::ROW_W-1:0]      row_ff;
   logic [ssba_pkg::ROW_W-1:0]      row_in;
   logic                            any_ff;

   // decision
   logic [ssba_pkg::STATUS_W-1:0]   st_ff, st_in;
   logic [ssba_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic                            xfer_ff, xfer_in;
   logic [ssba_pkg::STEP_W-1:0]     step_ff;

   logic [ssba_pkg::ROW_BITS-1:0]   row_data;
   logic [ssba_pkg::ROW_BITS-1:0]   limit_mask;
   logic [ssba_pkg::ROW_BITS-1:0]   cand;
   logic [ssba_pkg::ROW_BITS-1:0]   wdata;
   logic [ssba_pkg::BIT_W-1:0]      alloc_bit;
   logic [ssba_pkg::BIT_W-1:0]      idx_bit;
   logic [ssba_pkg::LIM_W-1:0]      lim_row;
   logic [ssba_pkg::LIM_W-1:0]      cur_row;
   logic                            map_we;
   logic                            in_range;
   logic                            emit_last;

   // output register
   logic                            rsp_valid_ff;
   logic [ssba_pkg::STATUS_W-1:0]   rsp_st_ff;
   logic [ssba_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [ssba_pkg::SECTOR_W-1:0]   rsp_sector_ff;
   logic [ssba_pkg::MEM_ADDR_W-1:0] rsp_addr_ff;
   logic                            rsp_xfer_ff;
   logic                            rsp_last_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff   <= req_tuser;
         idx_ff   <= req_tdata[ssba_pkg::SLOT_W-1:0];
         frame_ff <= req_tdata[ssba_pkg::SLOT_W +: ssba_pkg::FRAME_W];
      end
   end

   assign row_in = (cmd_ff == ssba_pkg::CMD_OUT) ? ssba_pkg::first_row(summary_ff) :
                   idx_ff[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_W];

   always_ff @(posedge clock) begin
      if (ctl_cmd.read) begin
         q_ff   <= map_mem[row_in];
         row_ff <= row_in;
         any_ff <= |summary_ff;
      end
      if (map_we && ctl_cmd.check) begin
         map_mem[row_ff] <= wdata;
      end
   end

   always_comb begin
      row_data   = row_valid_ff[row_ff] ? q_ff : '1;
      lim_row    = eff_count[ssba_pkg::COUNT_W-1:ssba_pkg::BIT_W];
      cur_row    = ssba_pkg::LIM_W'(row_ff);
      if (lim_row > cur_row) begin
         limit_mask = '1;
      end else if (lim_row == cur_row) begin
         limit_mask = (ssba_pkg::ROW_BITS'(1) << eff_count[ssba_pkg::BIT_W-1:0])
                      - ssba_pkg::ROW_BITS'(1);
      end else begin
         limit_mask = '0;
      end
      cand      = row_data & limit_mask;
      alloc_bit = ssba_pkg::first_bit(cand);
      idx_bit   = idx_ff[ssba_pkg::BIT_W-1:0];
      in_range  = ({1'b0, idx_ff} < eff_count);

      map_we       = 1'b0;
      wdata        = row_data;
      row_valid_in = row_valid_ff;
      summary_in   = summary_ff;
      st_in        = ssba_pkg::ST_OK;
      slot_in      = idx_ff;
      xfer_in      = 1'b0;

      case (cmd_ff) inside
         ssba_pkg::CMD_OUT: begin
            if (any_ff && (|cand)) begin
               slot_in = {row_ff, alloc_bit};
               xfer_in = 1'b1;
               map_we  = 1'b1;
               wdata   = row_data & ~(ssba_pkg::ROW_BITS'(1) << alloc_bit);
            end else begin
               st_in   = ssba_pkg::ST_FULL;
               slot_in = '0;
            end
         end
         ssba_pkg::CMD_IN, ssba_pkg::CMD_FREE: begin
            if (!in_range) begin
               st_in = ssba_pkg::ST_RANGE;
            end else if (row_data[idx_bit]) begin
               st_in = ssba_pkg::ST_UNUSED;
            end else begin
               map_we  = 1'b1;
               wdata   = row_data | (ssba_pkg::ROW_BITS'(1) << idx_bit);
               xfer_in = (cmd_ff == ssba_pkg::CMD_IN);
            end
         end
         default: begin
         end
      endcase

      if (map_we && ctl_cmd.check) begin
         row_valid_in[row_ff] = 1'b1;
         summary_in[row_ff]   = |wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         summary_ff   <= '1;
      end else begin
         row_valid_ff <= row_valid_in;
         summary_ff   <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.check) begin
         st_ff   <= st_in;
         slot_ff <= slot_in;
         xfer_ff <= xfer_in;
         step_ff <= '0;
      end else if (ctl_cmd.emit) begin
         step_ff <= step_ff + ssba_pkg::STEP_W'(1);
      end
   end

   assign emit_last = !xfer_ff ||
                      (step_ff == ssba_pkg::STEP_W'(ssba_pkg::SECTORS_PER_SLOT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.emit) begin
         rsp_st_ff   <= st_ff;
         rsp_slot_ff <= slot_ff;
         rsp_xfer_ff <= xfer_ff;
         rsp_last_ff <= emit_last;
         if (xfer_ff) begin
            rsp_sector_ff <= ssba_pkg::SECTOR_W'({slot_ff, step_ff});
            rsp_addr_ff   <= (ssba_pkg::MEM_ADDR_W'(frame_ff) << ssba_pkg::PAGE_SHIFT)
                           + (ssba_pkg::MEM_ADDR_W'(step_ff) << ssba_pkg::SECTOR_SHIFT);
         end else begin
            rsp_sector_ff <= '0;
            rsp_addr_ff   <= '0;
         end
      end
   end

   assign dp_stat.none      = (cmd_ff == ssba_pkg::CMD_NOP);
   assign dp_stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign dp_stat.emit_last = emit_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_addr_ff, rsp_sector_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_xfer_ff, rsp_st_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_row_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(row_valid_ff) & ~row_valid_ff) == '0))
      else $error("row valid bit dropped");

   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_xfer_ff) |-> (rsp_last_ff && rsp_sector_ff == '0))
      else $error("status-only result malformed");

   a_sector_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_xfer_ff) |->
      (rsp_sector_ff[ssba_pkg::SECTOR_W-1:ssba_pkg::STEP_W] == rsp_slot_ff))
      else $error("sector does not match slot");

   a_alloc_was_free: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.check && map_we && cmd_ff == ssba_pkg::CMD_OUT) |->
      row_data[alloc_bit])
      else $error("allocated a used slot");

endmodule

// ----- hdl/ssba_ctrl.sv -----
module ssba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output ssba_pkg::ctl_cmd_type  ctl_cmd,
   input  ssba_pkg::dp_stat_type  dp_stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      ctl_cmd       = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl_cmd.load = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            ctl_cmd.read = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            ctl_cmd.check = 1'b1;
            state_in      = dp_stat.none ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (dp_stat.out_free) begin
               ctl_cmd.emit = 1'b1;
               if (dp_stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load |=> (state_ff == S_READ))
      else $error("load did not start a read");

   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> (state_ff == S_EMIT && dp_stat.out_free))
      else $error("emit while output busy");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.check |-> $past(ctl_cmd.read))
      else $error("check without read");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [ssba_pkg::CMD_W-1:0]   cmd;
      logic [ssba_pkg::SLOT_W-1:0]  idx;
      logic [ssba_pkg::FRAME_W-1:0] frame;
   } swap_cmd_type;

   typedef struct {
      logic [ssba_pkg::STATUS_W-1:0]   status;
      logic [ssba_pkg::SLOT_W-1:0]     slot;
      logic [ssba_pkg::SECTOR_W-1:0]   sector;
      logic [ssba_pkg::MEM_ADDR_W-1:0] maddr;
      logic                            xfer;
      logic                            last;
   } slot_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ssba_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ssba_pkg::CMD_W-1:0]      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ssba_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ssba_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ssba_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ssba_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ssba_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   swap_slot_bitmap_allocator_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // shadow of the allocator
   logic                          slot_free [ssba_pkg::MAX_SLOTS];
   logic [ssba_pkg::COUNT_W-1:0]  cfg_slot_count = ssba_pkg::SLOT_COUNT_RESET;

   swap_cmd_type    cmd_queue[$];
   slot_result_type slot_results_due[$];
   swap_cmd_type    req_item;
   logic            req_busy = 1'b0;
   logic            req_taken = 1'b0;
   logic            rsp_taken = 1'b0;
   int              req_wait = 0;
   int              req_burst = 0;
   int              rsp_wait = 0;
   int              rsp_burst = 0;
   int              errors = 0;

   initial begin
      for (int i = 0; i < ssba_pkg::MAX_SLOTS; i++) slot_free[i] = 1'b1;
   end

   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void push_result(input logic [ssba_pkg::STATUS_W-1:0] status,
                                       input logic [ssba_pkg::SLOT_W-1:0] slot,
                                       input logic [ssba_pkg::SECTOR_W-1:0] sector,
                                       input logic [ssba_pkg::MEM_ADDR_W-1:0] maddr,
                                       input logic xfer, input logic last);
      slot_result_type r;
      r.status = status;
      r.slot   = slot;
      r.sector = sector;
      r.maddr  = maddr;
      r.xfer   = xfer;
      r.last   = last;
      slot_results_due.push_back(r);
   endfunction

   function automatic void push_transfers(input int unsigned slot,
                                          input logic [ssba_pkg::FRAME_W-1:0] frame);
      logic [ssba_pkg::MEM_ADDR_W-1:0] base;
      base = ssba_pkg::MEM_ADDR_W'(frame) * ssba_pkg::MEM_ADDR_W'(ssba_pkg::PAGE_BYTES);
      for (int k = 0; k < ssba_pkg::SECTORS_PER_SLOT; k++) begin
         push_result(ssba_pkg::ST_OK, ssba_pkg::SLOT_W'(slot),
                     ssba_pkg::SECTOR_W'(slot * ssba_pkg::SECTORS_PER_SLOT + k),
                     base + ssba_pkg::MEM_ADDR_W'(ssba_pkg::SECTOR_BYTES * k), 1'b1,
                     k == ssba_pkg::SECTORS_PER_SLOT - 1);
      end
   endfunction

   function automatic void compute_slot_results(input swap_cmd_type c);
      int unsigned lim;
      int          found;
      lim = (cfg_slot_count < ssba_pkg::MAX_SLOTS) ? 32'(cfg_slot_count)
                                                   : 32'(ssba_pkg::MAX_SLOTS);
      found = -1;
      case (c.cmd) inside
         ssba_pkg::CMD_OUT: begin
            for (int s = 0; s < lim; s++) begin
               if (slot_free[s]) begin
                  found = s;
                  break;
               end
            end
            if (found < 0) begin
               push_result(ssba_pkg::ST_FULL, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               slot_free[found] = 1'b0;
               push_transfers(32'(found), c.frame);
            end
         end
         ssba_pkg::CMD_IN, ssba_pkg::CMD_FREE: begin
            if (32'(c.idx) >= lim) begin
               push_result(ssba_pkg::ST_RANGE, c.idx, '0, '0, 1'b0, 1'b1);
            end else if (slot_free[c.idx]) begin
               push_result(ssba_pkg::ST_UNUSED, c.idx, '0, '0, 1'b0, 1'b1);
            end else begin
               slot_free[c.idx] = 1'b1;
               if (c.cmd == ssba_pkg::CMD_IN) begin
                  push_transfers(32'(c.idx), c.frame);
               end else begin
                  push_result(ssba_pkg::ST_OK, c.idx, '0, '0, 1'b0, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input longint unsigned exp_v,
                                       input longint unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         compute_slot_results(req_item);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_tvalid;
      if (req_taken) begin
         next_valid = 1'b0;
         req_busy = 1'b0;
      end
      if (!reset && !req_busy && cmd_queue.size() > 0) begin
         if (req_wait > 0) begin
            req_wait--;
         end else begin
            req_item = cmd_queue.pop_front();
            req_tdata <= ssba_pkg::REQ_DATA_W'({req_item.frame, req_item.idx});
            req_tuser <= req_item.cmd;
            next_valid = 1'b1;
            req_busy = 1'b1;
            req_wait = draw_gap(req_burst);
         end
      end
      req_tvalid <= next_valid;
   end

   // result monitor
   always @(posedge clock) begin
      slot_result_type exp_r;
      rsp_taken = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         if (slot_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none actual %0h/%0h/%0h",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            exp_r = slot_results_due.pop_front();
            check_field("status", exp_r.status, rsp_tuser[ssba_pkg::STATUS_W-1:0]);
            check_field("transfer", exp_r.xfer, rsp_tuser[ssba_pkg::STATUS_W]);
            check_field("slot", exp_r.slot, rsp_tdata[ssba_pkg::SLOT_W-1:0]);
            check_field("device_sector", exp_r.sector,
                        rsp_tdata[ssba_pkg::SLOT_W +: ssba_pkg::SECTOR_W]);
            check_field("memory_address", exp_r.maddr,
                        rsp_tdata[ssba_pkg::SLOT_W+ssba_pkg::SECTOR_W +:
                                  ssba_pkg::MEM_ADDR_W]);
            check_field("last", exp_r.last, rsp_tlast);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = draw_gap(rsp_burst);
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_cmd(input logic [ssba_pkg::CMD_W-1:0] cmd, input int unsigned idx,
                            input int unsigned frame);
      swap_cmd_type c;
      c.cmd   = cmd;
      c.idx   = ssba_pkg::SLOT_W'(idx);
      c.frame = ssba_pkg::FRAME_W'(frame);
      cmd_queue.push_back(c);
   endtask

   task automatic wait_idle();
      while (cmd_queue.size() != 0 || req_busy || slot_results_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [ssba_pkg::COUNT_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ssba_pkg::CSR_ADDR_W'({ssba_pkg::REG_SLOT_COUNT, 2'b00});
      csr_pwdata  <= ssba_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cfg_slot_count = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_random(input int n);
      int unsigned lim;
      int unsigned pick;
      int unsigned idx;
      int unsigned frame;
      logic [ssba_pkg::CMD_W-1:0] cmd;
      lim = (cfg_slot_count < ssba_pkg::MAX_SLOTS) ? 32'(cfg_slot_count)
                                                   : 32'(ssba_pkg::MAX_SLOTS);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) cmd = ssba_pkg::CMD_OUT;
         else if (pick < 70) cmd = ssba_pkg::CMD_IN;
         else if (pick < 95) cmd = ssba_pkg::CMD_FREE;
         else cmd = ssba_pkg::CMD_NOP;
         // first fit keeps live slots low, so aim most indexes there
         pick = $urandom_range(0, 99);
         if (pick < 70) idx = $urandom_range(0, 24);
         else if (pick < 85) idx = (lim + $urandom_range(0, 2) + 1023) % 1024;
         else idx = $urandom_range(0, 1023);
         pick = $urandom_range(0, 9);
         if (pick == 0) frame = 0;
         else if (pick == 1) frame = 20'hFFFFF;
         else frame = $urandom_range(0, 20'hFFFFF);
         queue_cmd(cmd, idx, frame);
      end
   endtask

   initial begin
      int unsigned counts[6];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_cmd(ssba_pkg::CMD_IN, 0, 20'h12345);
      queue_cmd(ssba_pkg::CMD_FREE, 1023, 0);
      queue_cmd(ssba_pkg::CMD_NOP, 1023, 20'hFFFFF);
      queue_cmd(ssba_pkg::CMD_OUT, 1023, 0);
      queue_cmd(ssba_pkg::CMD_OUT, 0, 20'hFFFFF);
      queue_cmd(ssba_pkg::CMD_OUT, 512, 20'h55555);
      queue_cmd(ssba_pkg::CMD_IN, 1, 20'hAAAAA);
      queue_cmd(ssba_pkg::CMD_FREE, 0, 20'hFFFFF);
      queue_cmd(ssba_pkg::CMD_FREE, 0, 0);
      queue_cmd(ssba_pkg::CMD_OUT, 0, 20'h80000);
      queue_cmd(ssba_pkg::CMD_IN, 1023, 20'hFFFFF);
      wait_idle();

      write_slot_count(0);
      queue_cmd(ssba_pkg::CMD_OUT, 0, 20'h00001);
      queue_cmd(ssba_pkg::CMD_IN, 0, 0);
      queue_cmd(ssba_pkg::CMD_FREE, 5, 0);
      queue_cmd(ssba_pkg::CMD_IN, 1023, 20'hFFFFF);
      wait_idle();

      write_slot_count(3);
      queue_cmd(ssba_pkg::CMD_OUT, 0, 20'h0F0F0);
      queue_cmd(ssba_pkg::CMD_OUT, 0, 20'hF0F0F);
      queue_cmd(ssba_pkg::CMD_FREE, 2, 0);
      queue_cmd(ssba_pkg::CMD_IN, 3, 0);
      queue_cmd(ssba_pkg::CMD_IN, 2, 0);
      wait_idle();

      write_slot_count(11'h7FF);
      queue_cmd(ssba_pkg::CMD_IN, 1023, 20'h00000);
      queue_cmd(ssba_pkg::CMD_IN, 1, 20'hFFFFF);
      queue_cmd(ssba_pkg::CMD_OUT, 341, 20'h33333);
      wait_idle();

      counts = '{1024, 6, 2047, $urandom_range(0, 2047), 1, $urandom_range(2, 40)};
      foreach (counts[p]) begin
         write_slot_count(ssba_pkg::COUNT_W'(counts[p]));
         queue_random(33);
         wait_idle();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
